// ===== rtl/core/llss_pkg.sv =====
`timescale 1ns / 1ps

package llss_pkg;

  // default sizes of the link table
  localparam int NUM_TORS_DEF   = 64;
  localparam int NUM_SPINES_DEF = 16;
  localparam int COUNT_BITS_DEF = 48;

  // fixed port field widths
  localparam int TOR_W   = 6;
  localparam int SPINE_W = 4;
  localparam int BYTE_W  = 48;
  localparam int MASK_W  = 16;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_CHOOSE = 2'd1,
    KIND_READ   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LINK_RD,
    ST_LINK_USE,
    ST_CH_ISSUE,
    ST_CH_DRAIN,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/core/llss_ram.sv =====
`timescale 1ns / 1ps

module llss_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== rtl/core/least_loaded_spine_selector.sv =====
`timescale 1ns / 1ps
// add and read requests: pass through the link read, link use and done states, then the output register
// choose requests: one spine per cycle over min(NUM_SPINES, 16) spines, then the compare pipeline
//   drains; the result passes from the done state to the output register, and the next request is
//   taken once the block is back in idle
// one request is worked on at a time; a finished result waits in the done state until the output register is free
// reset: asynchronous, active low; afterwards a clearing pass writes zero to all
//   NUM_TORS * NUM_SPINES table entries, one per cycle, with in_stall_o high throughout

module least_loaded_spine_selector
  import llss_pkg::*;
#(
  parameter int NUM_TORS   = NUM_TORS_DEF,
  parameter int NUM_SPINES = NUM_SPINES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic [TOR_W-1:0]   source_tor_i,
  input  logic [TOR_W-1:0]   destination_tor_i,
  input  logic [SPINE_W-1:0] spine_i,
  input  logic [BYTE_W-1:0]  byte_count_i,
  input  logic [MASK_W-1:0]  available_mask_i,

  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [SPINE_W-1:0] chosen_spine_o,
  output logic [BYTE_W-1:0]  byte_result_o,
  output logic               empty_error_o
);

  // table geometry: entry index is tor * NUM_SPINES + spine
  localparam int DEPTH = NUM_TORS * NUM_SPINES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // spines walked by choose: mask only covers the first MASK_W
  localparam int NSCAN = (NUM_SPINES < MASK_W) ? NUM_SPINES : MASK_W;
  localparam int SCW   = (NSCAN > 1) ? $clog2(NSCAN) : 1;
  // sum width: wide enough for count plus added bytes without wrap
  localparam int XW    = ((COUNT_BITS > BYTE_W) ? COUNT_BITS : BYTE_W) + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  state_e state_q, state_d;

  // captured request
  kind_e                kind_q, kind_d;
  logic [TOR_W-1:0]     src_q, src_d;
  logic [TOR_W-1:0]     dst_q, dst_d;
  logic [SPINE_W-1:0]   spine_q, spine_d;
  logic [BYTE_W-1:0]    bytes_q, bytes_d;
  logic [MASK_W-1:0]    mask_q, mask_d;   // shifted right once per scanned spine
  logic                 ok_q, ok_d;       // link in range for add / read
  logic                 src_ok_q, src_ok_d;
  logic                 dst_ok_q, dst_ok_d;

  // clearing pass and scan counters
  logic [AW-1:0]        clr_q, clr_d;
  logic [SCW-1:0]       cnt_q, cnt_d;

  // choose pipeline: stage 1 waits on ram data, stage 2 holds the path cost
  logic                 p1_valid_q, p1_valid_d;
  logic [SCW-1:0]       p1_spine_q, p1_spine_d;
  logic                 p2_valid_q, p2_valid_d;
  logic [SCW-1:0]       p2_spine_q, p2_spine_d;
  logic [COUNT_BITS-1:0] cost_q, cost_d;

  // running best of the choose scan
  logic                 found_q, found_d;
  logic [COUNT_BITS-1:0] best_q, best_d;
  logic [SCW-1:0]       best_spine_q, best_spine_d;

  // result of add / read
  logic [BYTE_W-1:0]    res_bytes_q, res_bytes_d;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic [SPINE_W-1:0]   out_spine_q, out_spine_d;
  logic [BYTE_W-1:0]    out_bytes_q, out_bytes_d;
  logic                 out_err_q, out_err_d;

  // link table ports
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr_a;
  logic [AW-1:0]         ram_raddr_b;
  logic [COUNT_BITS-1:0] ram_rdata_a;
  logic [COUNT_BITS-1:0] ram_rdata_b;

  logic                  in_accept;
  logic                  out_free;
  logic [AW-1:0]         addr_link;
  logic [AW-1:0]         addr_src_scan;
  logic [AW-1:0]         addr_dst_scan;
  logic [XW-1:0]         sum;
  logic [COUNT_BITS-1:0] new_count;
  logic [COUNT_BITS-1:0] load_a;
  logic [COUNT_BITS-1:0] load_b;

  llss_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // entry addresses; out-of-range leaves are never written and their reads are masked
  assign addr_link     = AW'(int'(src_q) * NUM_SPINES + int'(spine_q));
  assign addr_src_scan = AW'(int'(src_q) * NUM_SPINES + int'(cnt_q));
  assign addr_dst_scan = AW'(int'(dst_q) * NUM_SPINES + int'(cnt_q));

  assign ram_raddr_a = (state_q == ST_CH_ISSUE) ? addr_src_scan : addr_link;
  assign ram_raddr_b = addr_dst_scan;

  // saturating add, one wide add and compare
  assign sum       = XW'(ram_rdata_a) + XW'(bytes_q);
  assign new_count = (sum > XW'(CNT_MAX)) ? CNT_MAX : sum[COUNT_BITS-1:0];

  // path cost inputs: a leaf outside the table counts as empty
  assign load_a = src_ok_q ? ram_rdata_a : '0;
  assign load_b = dst_ok_q ? ram_rdata_b : '0;

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    src_d        = src_q;
    dst_d        = dst_q;
    spine_d      = spine_q;
    bytes_d      = bytes_q;
    mask_d       = mask_q;
    ok_d         = ok_q;
    src_ok_d     = src_ok_q;
    dst_ok_d     = dst_ok_q;
    clr_d        = clr_q;
    cnt_d        = cnt_q;
    found_d      = found_q;
    best_d       = best_q;
    best_spine_d = best_spine_q;
    res_bytes_d  = res_bytes_q;
    out_spine_d  = out_spine_q;
    out_bytes_d  = out_bytes_q;
    out_err_d    = out_err_q;
    out_valid_d  = out_valid_q && out_stall_i;

    ram_we    = 1'b0;
    ram_waddr = addr_link;
    ram_wdata = new_count;

    // choose pipeline advances every cycle; only issue fills stage 1
    p1_valid_d = 1'b0;
    p1_spine_d = cnt_q;
    p2_valid_d = p1_valid_q;
    p2_spine_d = p1_spine_q;
    cost_d     = (load_a > load_b) ? load_a : load_b;

    // strict less-than keeps the lowest spine on equal cost
    if (p2_valid_q && (!found_q || cost_q < best_q)) begin
      found_d      = 1'b1;
      best_d       = cost_q;
      best_spine_d = p2_spine_q;
    end

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_accept) begin
          kind_d      = kind_e'(kind_i);
          src_d       = source_tor_i;
          dst_d       = destination_tor_i;
          spine_d     = spine_i;
          bytes_d     = byte_count_i;
          mask_d      = available_mask_i;
          src_ok_d    = int'(source_tor_i) < NUM_TORS;
          dst_ok_d    = int'(destination_tor_i) < NUM_TORS;
          ok_d        = (int'(source_tor_i) < NUM_TORS) && (int'(spine_i) < NUM_SPINES);
          cnt_d       = '0;
          found_d     = 1'b0;
          res_bytes_d = '0;
          unique case (kind_e'(kind_i))
            KIND_ADD:    state_d = ST_LINK_RD;
            KIND_READ:   state_d = ST_LINK_RD;
            KIND_CHOOSE: state_d = ST_CH_ISSUE;
            default:     state_d = ST_DONE;   // unused kind gives an all-zero result
          endcase
        end
      end

      ST_LINK_RD: begin
        state_d = ST_LINK_USE;
      end

      ST_LINK_USE: begin
        if (kind_q == KIND_ADD) begin
          ram_we = ok_q;
          if (ok_q) begin
            res_bytes_d = BYTE_W'(XW'(new_count));
          end
        end else if (ok_q) begin
          res_bytes_d = BYTE_W'(XW'(ram_rdata_a));
        end
        state_d = ST_DONE;
      end

      ST_CH_ISSUE: begin
        p1_valid_d = mask_q[0];
        mask_d     = mask_q >> 1;
        cnt_d      = cnt_q + SCW'(1);
        if (cnt_q == SCW'(NSCAN - 1)) begin
          state_d = ST_CH_DRAIN;
        end
      end

      ST_CH_DRAIN: begin
        if (!p1_valid_q && !p2_valid_q) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (kind_q == KIND_CHOOSE) begin
            out_err_d   = !found_q;
            out_spine_d = found_q ? SPINE_W'(best_spine_q) : '0;
            out_bytes_d = found_q ? BYTE_W'(XW'(best_q)) : '0;
          end else begin
            out_err_d   = 1'b0;
            out_spine_d = '0;
            out_bytes_d = res_bytes_q;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      p1_valid_q  <= 1'b0;
      p2_valid_q  <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      p1_valid_q  <= p1_valid_d;
      p2_valid_q  <= p2_valid_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    src_q        <= src_d;
    dst_q        <= dst_d;
    spine_q      <= spine_d;
    bytes_q      <= bytes_d;
    mask_q       <= mask_d;
    ok_q         <= ok_d;
    src_ok_q     <= src_ok_d;
    dst_ok_q     <= dst_ok_d;
    cnt_q        <= cnt_d;
    p1_spine_q   <= p1_spine_d;
    p2_spine_q   <= p2_spine_d;
    cost_q       <= cost_d;
    best_q       <= best_d;
    best_spine_q <= best_spine_d;
    res_bytes_q  <= res_bytes_d;
    out_spine_q  <= out_spine_d;
    out_bytes_q  <= out_bytes_d;
    out_err_q    <= out_err_d;
  end

  assign out_valid_o    = out_valid_q;
  assign chosen_spine_o = out_spine_q;
  assign byte_result_o  = out_bytes_q;
  assign empty_error_o  = out_err_q;

  // table is written only by the clearing pass or the write-back of an add
  a_write_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR || state_q == ST_LINK_USE))
    else $error("link table written outside clear or add write-back");

  // an empty choice carries no spine and no cost
  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && empty_error_o) |-> (chosen_spine_o == '0 && byte_result_o == '0))
    else $error("empty choice with nonzero payload");

  // choose pipeline only runs during a choose scan
  a_pipe_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p1_valid_q || p2_valid_q) |-> (state_q == ST_CH_ISSUE || state_q == ST_CH_DRAIN))
    else $error("choose pipeline active outside scan");

  // a new result only leaves the done state
  a_result_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result raised outside done state");

endmodule

// ===== tb/llss_result_checker.sv =====
`timescale 1ns / 1ps

module llss_result_checker
  import llss_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         kind_i,
  input  logic [TOR_W-1:0]   source_tor_i,
  input  logic [TOR_W-1:0]   destination_tor_i,
  input  logic [SPINE_W-1:0] spine_i,
  input  logic [BYTE_W-1:0]  byte_count_i,
  input  logic [MASK_W-1:0]  available_mask_i,

  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [SPINE_W-1:0] chosen_spine_i,
  input  logic [BYTE_W-1:0]  byte_result_i,
  input  logic               empty_error_i,

  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [SPINE_W-1:0] spine;
    logic [BYTE_W-1:0]  bytes;
    logic               empty;
  } outcome_t;

  localparam logic [BYTE_W-1:0] LOAD_MAX = '1;

  logic [BYTE_W-1:0] link_loads [NUM_TORS_DEF][NUM_SPINES_DEF];
  outcome_t          queued_outcomes [$];
  int                fails = 0;

  // updates the link table for one request and returns its result
  function automatic outcome_t step_link_table(
    input logic [1:0]         kind,
    input logic [TOR_W-1:0]   src,
    input logic [TOR_W-1:0]   dst,
    input logic [SPINE_W-1:0] sp,
    input logic [BYTE_W-1:0]  bytes,
    input logic [MASK_W-1:0]  mask
  );
    outcome_t          o;
    logic [BYTE_W:0]   sum;
    logic [BYTE_W-1:0] cost;
    logic [BYTE_W-1:0] best;
    bit                found;
    o     = '0;
    best  = '0;
    found = 1'b0;
    case (kind)
      KIND_ADD: begin
        // saturating accumulate
        sum = {1'b0, link_loads[src][sp]} + {1'b0, bytes};
        link_loads[src][sp] = sum[BYTE_W] ? LOAD_MAX : sum[BYTE_W-1:0];
        o.bytes = link_loads[src][sp];
      end
      KIND_CHOOSE: begin
        for (int i = 0; i < NUM_SPINES_DEF; i++) begin
          if (mask[i]) begin
            cost = (link_loads[src][i] > link_loads[dst][i]) ?
                   link_loads[src][i] : link_loads[dst][i];
            // strict compare keeps the lowest spine on ties
            if (!found || cost < best) begin
              found   = 1'b1;
              best    = cost;
              o.spine = SPINE_W'(i);
            end
          end
        end
        if (found) begin
          o.bytes = best;
        end else begin
          o.empty = 1'b1;
        end
      end
      KIND_READ: begin
        o.bytes = link_loads[src][sp];
      end
      default: begin
        o = '0;
      end
    endcase
    return o;
  endfunction

  always @(posedge clk_i) begin
    outcome_t want;
    if (!rst_ni) begin
      foreach (link_loads[t, s]) link_loads[t][s] = '0;
      queued_outcomes.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        queued_outcomes.push_back(step_link_table(kind_i, source_tor_i, destination_tor_i,
                                                  spine_i, byte_count_i, available_mask_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (queued_outcomes.size() == 0) begin
          $display("%0t: result with none outstanding: spine %0d bytes %0d empty %0b",
                   $time, chosen_spine_i, byte_result_i, empty_error_i);
          fails++;
        end else begin
          want = queued_outcomes.pop_front();
          if (chosen_spine_i !== want.spine) begin
            $display("%0t: chosen_spine expected %0d got %0d", $time, want.spine,
                     chosen_spine_i);
            fails++;
          end
          if (byte_result_i !== want.bytes) begin
            $display("%0t: byte_result expected %0d got %0d", $time, want.bytes,
                     byte_result_i);
            fails++;
          end
          if (empty_error_i !== want.empty) begin
            $display("%0t: empty_error expected %0b got %0b", $time, want.empty,
                     empty_error_i);
            fails++;
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= queued_outcomes.size();
  end

endmodule

// ===== tb/least_loaded_spine_selector_tb.sv =====
`timescale 1ns / 1ps

module least_loaded_spine_selector_tb;
  import llss_pkg::*;

  // kind code the block leaves unused
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic               clk_i             = 1'b0;
  logic               rst_ni            = 1'b0;
  logic               in_valid_i        = 1'b0;
  logic [1:0]         kind_i            = '0;
  logic [TOR_W-1:0]   source_tor_i      = '0;
  logic [TOR_W-1:0]   destination_tor_i = '0;
  logic [SPINE_W-1:0] spine_i           = '0;
  logic [BYTE_W-1:0]  byte_count_i      = '0;
  logic [MASK_W-1:0]  available_mask_i  = '0;
  logic               out_stall_i       = 1'b0;

  logic               in_stall_o;
  logic               out_valid_o;
  logic [SPINE_W-1:0] chosen_spine_o;
  logic [BYTE_W-1:0]  byte_result_o;
  logic               empty_error_o;

  // percent of cycles the request side holds off and the result side stalls
  int idle_pct  = 0;
  int stall_pct = 0;

  int fail_count;
  int pending;

  least_loaded_spine_selector DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .kind_i            (kind_i),
    .source_tor_i      (source_tor_i),
    .destination_tor_i (destination_tor_i),
    .spine_i           (spine_i),
    .byte_count_i      (byte_count_i),
    .available_mask_i  (available_mask_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .chosen_spine_o    (chosen_spine_o),
    .byte_result_o     (byte_result_o),
    .empty_error_o     (empty_error_o)
  );

  // watches both channels, predicts every result and compares it
  llss_result_checker checker_inst (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .kind_i            (kind_i),
    .source_tor_i      (source_tor_i),
    .destination_tor_i (destination_tor_i),
    .spine_i           (spine_i),
    .byte_count_i      (byte_count_i),
    .available_mask_i  (available_mask_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .chosen_spine_i    (chosen_spine_o),
    .byte_result_i     (byte_result_o),
    .empty_error_i     (empty_error_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  // 100 MHz clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // result side back-pressure, redrawn every cycle
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // hard stop well beyond the slowest legal run, clearing pass included
  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  // offers one request, after a random hold-off, and returns once it is taken
  task automatic send_req(
    input logic [1:0]         kind,
    input logic [TOR_W-1:0]   src,
    input logic [TOR_W-1:0]   dst,
    input logic [SPINE_W-1:0] sp,
    input logic [BYTE_W-1:0]  bytes,
    input logic [MASK_W-1:0]  mask
  );
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    kind_i            <= kind;
    source_tor_i      <= src;
    destination_tor_i <= dst;
    spine_i           <= sp;
    byte_count_i      <= bytes;
    available_mask_i  <= mask;
    // stall is sampled as it stood just before the edge
    do @(posedge clk_i); while (in_stall_o);
  endtask

  initial begin
    logic [1:0]         kind;
    logic [TOR_W-1:0]   src;
    logic [TOR_W-1:0]   dst;
    logic [SPINE_W-1:0] sp;
    logic [BYTE_W-1:0]  bytes;
    logic [MASK_W-1:0]  mask;
    logic [63:0]        wide;
    bit                 hot;
    int                 pick;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed requests, no hold-off and no stall
    // untouched link reads zero
    send_req(KIND_READ, 0, 0, 0, 0, 0);
    // empty mask raises the error flag
    send_req(KIND_CHOOSE, 63, 0, 0, 0, 16'h0000);
    // all spines tie at zero, lowest spine wins
    send_req(KIND_CHOOSE, 0, 63, 15, '1, 16'hFFFF);
    // largest add, then one more byte saturates
    send_req(KIND_ADD, 63, 0, 15, 48'hFFFF_FFFF_FFFF, 0);
    send_req(KIND_ADD, 63, 0, 15, 1, 0);
    // zero add
    send_req(KIND_ADD, 0, 0, 0, 0, 0);
    // land exactly on the maximum, then go past it
    send_req(KIND_ADD, 1, 0, 2, 48'hFFFF_FFFF_FFFE, 0);
    send_req(KIND_ADD, 1, 0, 2, 1, 0);
    send_req(KIND_ADD, 1, 0, 2, 1, 0);
    // path cost is the larger of the two link loads
    send_req(KIND_ADD, 5, 0, 3, 100, 0);
    send_req(KIND_ADD, 7, 0, 3, 200, 0);
    send_req(KIND_ADD, 5, 0, 1, 300, 0);
    send_req(KIND_CHOOSE, 5, 7, 0, 0, 16'h000A);
    // equal cost on two spines picks the lower one
    send_req(KIND_ADD, 10, 0, 4, 50, 0);
    send_req(KIND_ADD, 10, 0, 6, 50, 0);
    send_req(KIND_CHOOSE, 10, 11, 0, 0, 16'h0050);
    // single top spine carrying a saturated load
    send_req(KIND_CHOOSE, 63, 0, 0, 0, 16'h8000);
    // source and destination on the same leaf
    send_req(KIND_CHOOSE, 63, 63, 0, 0, 16'hFFFF);
    send_req(KIND_CHOOSE, 5, 5, 0, 0, 16'hFFFE);
    // unused kind with every field high gives an all-zero result
    send_req(KIND_UNUSED, 63, 63, 15, '1, 16'hFFFF);
    // read back saturated and plain counts
    send_req(KIND_READ, 63, 0, 15, 0, 0);
    send_req(KIND_READ, 5, 0, 3, 0, 0);
    send_req(KIND_READ, 1, 63, 2, '1, 16'hFFFF);

    // random requests over four flow-control phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 84; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 84; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      repeat (185) begin
        pick = $urandom_range(99);
        if (pick < 40)      kind = KIND_ADD;
        else if (pick < 75) kind = KIND_CHOOSE;
        else if (pick < 95) kind = KIND_READ;
        else                kind = KIND_UNUSED;
        // most requests stay on a few leaves with small adds so that loads
        // build up and choose sees close and tied costs
        hot = ($urandom_range(99) < 70);
        src = hot ? TOR_W'($urandom_range(7)) : TOR_W'($urandom_range(63));
        dst = hot ? TOR_W'($urandom_range(7)) : TOR_W'($urandom_range(63));
        sp  = SPINE_W'($urandom_range(15));
        wide = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (hot)            bytes = BYTE_W'($urandom_range(4095));
        else if (pick < 80) bytes = wide[BYTE_W-1:0];
        else                bytes = {BYTE_W{1'b1}} - BYTE_W'($urandom_range(15));
        pick = $urandom_range(99);
        if (pick < 10)      mask = 16'h0001 << $urandom_range(15);
        else if (pick < 13) mask = '0;
        else                mask = MASK_W'($urandom);
        send_req(kind, src, dst, sp, bytes, mask);
      end
    end
    in_valid_i <= 1'b0;

    // drain outstanding results, then give a stray result time to show up
    do @(posedge clk_i); while (pending != 0);
    repeat (50) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/llss_pkg.sv
rtl/core/llss_ram.sv
rtl/core/least_loaded_spine_selector.sv
tb/llss_result_checker.sv
tb/least_loaded_spine_selector_tb.sv
